### rtl/btrd_pkg.sv
// ----------------------------------------------------------------------------
// btrd_pkg: shared types and constants of the task release dispatcher
// Request and result layouts, the task table entry and time helpers.
// ----------------------------------------------------------------------------
package btrd_pkg;

  localparam int unsigned NTASK  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned TIME_W = 32;

  localparam logic [2:0] FUNC_ADD_PER  = 3'd0;
  localparam logic [2:0] FUNC_ADD_EVT  = 3'd1;
  localparam logic [2:0] FUNC_NOTIFY   = 3'd2;
  localparam logic [2:0] FUNC_POLL     = 3'd3;
  localparam logic [2:0] FUNC_COMPLETE = 3'd4;
  localparam logic [2:0] FUNC_QUERY    = 3'd5;

  localparam logic [2:0] KIND_ACCEPT   = 3'd0;
  localparam logic [2:0] KIND_REJECT   = 3'd1;
  localparam logic [2:0] KIND_DISPATCH = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_COMPL    = 3'd4;
  localparam logic [2:0] KIND_REPORT   = 3'd5;

  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_DEGRADED  = 2'd1;
  localparam logic [1:0] MODE_EMERGENCY = 2'd2;

  localparam logic [1:0] CFG_DEGRADED  = 2'd0;
  localparam logic [1:0] CFG_EMERGENCY = 2'd1;
  localparam logic [1:0] CFG_RECOVERY  = 2'd2;

  typedef struct packed {
    logic [2:0]        func;
    logic [1:0]        priority_req;
    logic [TIME_W-1:0] rel_period;
    logic [TIME_W-1:0] exec_budget;
    logic [IDX_W-1:0]  task_index;
    logic [TIME_W-1:0] now_us;
  } req_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [IDX_W-1:0]  task_id;
    logic [TIME_W-1:0] start_time;
    logic [1:0]        sched_mode;
    logic [15:0]       miss_count;
    logic [15:0]       skip_count;
    logic [15:0]       denial_count;
    logic [15:0]       overrun_total;
    logic [TIME_W-1:0] last_run_us;
    logic [TIME_W-1:0] longest_run_us;
    logic [CNT_W-1:0]  tasks_in_use;
    logic [15:0]       mode_changes;
  } res_t;

  typedef struct packed {
    logic [1:0]        cls;
    logic              is_event;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] budget;
    logic [TIME_W-1:0] next_rel;
    logic              pending;
    logic [15:0]       misses;
    logic [15:0]       skips;
    logic [15:0]       denials;
    logic [15:0]       overruns;
    logic [TIME_W-1:0] last_exec;
    logic [TIME_W-1:0] max_exec;
  } entry_t;

  // Add that sticks at the largest time instead of wrapping.
  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a,
                                                logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

### rtl/budgeted_task_release_dispatcher.sv
// ----------------------------------------------------------------------------
// budgeted_task_release_dispatcher: fixed-priority periodic and event task dispatcher
// Task table in RAM, scheduling pass sequencer, budget checks and modes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done_o high, and it cannot be held off.
// The whole task table lives in one RAM with a registered read, so notify,
// complete and poll commands are a read, a modify and a write-back; an add
// only writes and a query only reads. A complete of a periodic task that has
// fallen at least one period behind uses the remainder unit. A poll visits
// the slots class by class, scans every registered task for the next
// higher-class release when a mission or background task with a budget is
// due, and uses the remainder unit for each skipped release that has fallen
// at least one period behind. The remainder unit and the single RAM read port
// set the pace of a pass. Configuration writes are always taken (cfg_ready_o
// is tied high) and apply to the next pass end.
module budgeted_task_release_dispatcher (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  btrd_pkg::req_t  req_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  output logic            done_o,
  output btrd_pkg::res_t  res_o
);
  import btrd_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NT_EV   = 4'd1;
  localparam logic [3:0] S_QY_EV   = 4'd2;
  localparam logic [3:0] S_CP_EV   = 4'd3;
  localparam logic [3:0] S_WK_SEL  = 4'd4;
  localparam logic [3:0] S_WK_EV   = 4'd5;
  localparam logic [3:0] S_HR_RD   = 4'd6;
  localparam logic [3:0] S_HR_EV   = 4'd7;
  localparam logic [3:0] S_DISP    = 4'd8;
  localparam logic [3:0] S_AD_CALC = 4'd9;
  localparam logic [3:0] S_AD_WAIT = 4'd10;
  localparam logic [3:0] S_END     = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  logic [3:0]        state_q, state_d;
  req_t              req_q, req_d;
  entry_t            ent_q, ent_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [1:0]        mode_q, mode_d;
  logic              flag_q, flag_d;
  logic [7:0]        vstreak_q, vstreak_d, cstreak_q, cstreak_d;
  logic [2:0]        cclass_q, cclass_d;
  logic [CNT_W-1:0]  cslot_q, cslot_d;
  logic              pass_q, pass_d;
  logic              run_v_q, run_v_d;
  logic [IDX_W-1:0]  run_slot_q, run_slot_d;
  logic [TIME_W-1:0] run_start_q, run_start_d;
  logic [15:0]       trans_q, trans_d;
  logic [7:0]        deg_q, emg_q, rec_q;
  logic [CNT_W-1:0]  hr_idx_q, hr_idx_d;
  logic              hr_found_q, hr_found_d;
  logic [TIME_W-1:0] hr_rel_q, hr_rel_d;
  logic [2:0]        rkind_q, rkind_d;
  logic [IDX_W-1:0]  rid_q, rid_d;
  logic [TIME_W-1:0] rstart_q, rstart_d;
  logic              rfill_q, rfill_d;
  logic [TIME_W-1:0] ad_base_q, ad_base_d;
  logic              ad_walk_q, ad_walk_d;
  res_t              out_q, out_d;
  logic              done_q, done_d;

  // Table RAM and remainder unit connections.
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata, rdata;
  logic              div_start, div_done;
  logic [TIME_W-1:0] div_dvd, div_rem;

  // Scratch values of the sequencer.
  entry_t            e;
  logic [1:0]        c;
  logic              allowed, due;
  logic [TIME_W-1:0] ex, n, nr;
  logic [7:0]        vs_n, cs_n;
  logic [1:0]        mnext;

  btrd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NTASK)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  btrd_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (ent_q.period),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    ent_d       = ent_q;
    cur_d       = cur_q;
    used_d      = used_q;
    mode_d      = mode_q;
    flag_d      = flag_q;
    vstreak_d   = vstreak_q;
    cstreak_d   = cstreak_q;
    cclass_d    = cclass_q;
    cslot_d     = cslot_q;
    pass_d      = pass_q;
    run_v_d     = run_v_q;
    run_slot_d  = run_slot_q;
    run_start_d = run_start_q;
    trans_d     = trans_q;
    hr_idx_d    = hr_idx_q;
    hr_found_d  = hr_found_q;
    hr_rel_d    = hr_rel_q;
    rkind_d     = rkind_q;
    rid_d       = rid_q;
    rstart_d    = rstart_q;
    rfill_d     = rfill_q;
    ad_base_d   = ad_base_q;
    ad_walk_d   = ad_walk_q;
    out_d       = out_q;
    done_d      = 1'b0;
    we          = 1'b0;
    waddr       = cur_q;
    wdata       = ent_q;
    raddr       = cur_q;
    div_start   = 1'b0;
    div_dvd     = '0;
    e           = rdata;
    c           = cclass_q[1:0];
    allowed     = 1'b0;
    due         = 1'b0;
    ex          = '0;
    n           = '0;
    nr          = '0;
    vs_n        = '0;
    cs_n        = '0;
    mnext       = mode_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d    = req_i;
          rkind_d  = KIND_REJECT;
          rid_d    = '0;
          rstart_d = '0;
          rfill_d  = 1'b0;
          state_d  = S_RESP;
          unique case (req_i.func)
            FUNC_ADD_PER, FUNC_ADD_EVT: begin
              if (used_q != CNT_W'(NTASK)) begin
                wdata          = '0;
                wdata.cls      = req_i.priority_req;
                wdata.is_event = (req_i.func == FUNC_ADD_EVT);
                if (req_i.func == FUNC_ADD_PER) begin
                  wdata.period   = req_i.rel_period;
                  wdata.next_rel = sat_add(req_i.now_us, req_i.rel_period);
                end
                wdata.budget = req_i.exec_budget;
                waddr        = used_q[IDX_W-1:0];
                we           = 1'b1;
                used_d       = used_q + CNT_W'(1);
                rkind_d      = KIND_ACCEPT;
                rid_d        = used_q[IDX_W-1:0];
              end
            end
            FUNC_NOTIFY, FUNC_QUERY: begin
              if ({1'b0, req_i.task_index} < used_q) begin
                raddr   = req_i.task_index;
                cur_d   = req_i.task_index;
                state_d = (req_i.func == FUNC_NOTIFY) ? S_NT_EV : S_QY_EV;
              end
            end
            FUNC_POLL: begin
              if (!run_v_q) begin
                if (!pass_q) begin
                  pass_d   = 1'b1;
                  flag_d   = 1'b0;
                  cclass_d = '0;
                  cslot_d  = '0;
                end
                state_d = S_WK_SEL;
              end
            end
            FUNC_COMPLETE: begin
              if (run_v_q) begin
                raddr   = run_slot_q;
                cur_d   = run_slot_q;
                state_d = S_CP_EV;
              end
            end
            default: ;
          endcase
        end
      end

      S_NT_EV: begin
        if (rdata.is_event) begin
          wdata         = rdata;
          wdata.pending = 1'b1;
          we            = 1'b1;
          rkind_d       = KIND_ACCEPT;
          rid_d         = cur_q;
        end
        state_d = S_RESP;
      end

      S_QY_EV: begin
        ent_d   = rdata;
        rkind_d = KIND_REPORT;
        rid_d   = cur_q;
        rfill_d = 1'b1;
        state_d = S_RESP;
      end

      S_CP_EV: begin
        // A clock that went backwards counts as a budget overrun for a task with a nonzero budget.
        ex = (req_q.now_us >= run_start_q) ? req_q.now_us - run_start_q
                                           : sat_add(rdata.budget, TIME_W'(1));
        e.last_exec = ex;
        if (ex > rdata.max_exec) begin
          e.max_exec = ex;
        end
        if (rdata.budget != '0 && ex > rdata.budget) begin
          e.overruns = inc16(rdata.overruns);
          if (!rdata.cls[1]) begin
            flag_d = 1'b1;
          end
        end
        run_v_d = 1'b0;
        rkind_d = KIND_COMPL;
        rid_d   = cur_q;
        rfill_d = 1'b1;
        if (!rdata.is_event) begin
          ad_base_d = run_start_q;
          ad_walk_d = 1'b0;
          state_d   = S_AD_CALC;
        end else begin
          e.pending = 1'b0;
          wdata     = e;
          we        = 1'b1;
          state_d   = S_RESP;
        end
        ent_d = e;
      end

      S_WK_SEL: begin
        allowed = !c[1] || (c == 2'd2 && mode_q != MODE_EMERGENCY) ||
                  (c == 2'd3 && mode_q == MODE_NORMAL);
        if (cclass_q[2]) begin
          state_d = S_END;
        end else if (!allowed || cslot_q >= used_q) begin
          cclass_d = cclass_q + 3'd1;
          cslot_d  = '0;
        end else begin
          raddr   = cslot_q[IDX_W-1:0];
          cur_d   = cslot_q[IDX_W-1:0];
          cslot_d = cslot_q + CNT_W'(1);
          state_d = S_WK_EV;
        end
      end

      S_WK_EV: begin
        ent_d      = rdata;
        hr_found_d = 1'b0;
        hr_idx_d   = '0;
        due = rdata.is_event ? rdata.pending : (req_q.now_us >= rdata.next_rel);
        if (rdata.cls != c || !due) begin
          state_d = S_WK_SEL;
        end else if (!rdata.is_event && rdata.budget != '0 &&
                     req_q.now_us > sat_add(rdata.next_rel, rdata.budget)) begin
          // Release is past its budget: skip it and move to the next one.
          e.misses  = inc16(rdata.misses);
          e.skips   = inc16(rdata.skips);
          ent_d     = e;
          if (!c[1]) begin
            flag_d = 1'b1;
          end
          ad_base_d = req_q.now_us;
          ad_walk_d = 1'b1;
          state_d   = S_AD_CALC;
        end else if (c[1] && rdata.budget != '0) begin
          state_d = S_HR_RD;
        end else begin
          state_d = S_DISP;
        end
      end

      S_HR_RD: begin
        if (hr_idx_q >= used_q) begin
          state_d = S_DISP;
        end else begin
          raddr    = hr_idx_q[IDX_W-1:0];
          hr_idx_d = hr_idx_q + CNT_W'(1);
          state_d  = S_HR_EV;
        end
      end

      S_HR_EV: begin
        if (!rdata.is_event && rdata.cls < c && rdata.period != '0 &&
            (!hr_found_q || rdata.next_rel < hr_rel_q)) begin
          hr_rel_d   = rdata.next_rel;
          hr_found_d = 1'b1;
        end
        state_d = S_HR_RD;
      end

      S_DISP: begin
        e = ent_q;
        if (hr_found_q && req_q.now_us < hr_rel_q &&
            (hr_rel_q - req_q.now_us) < ent_q.budget) begin
          // The budget would run into a higher-class release.
          e.denials = inc16(ent_q.denials);
          state_d   = S_WK_SEL;
        end else begin
          if (!ent_q.is_event && req_q.now_us > ent_q.next_rel) begin
            e.misses = inc16(ent_q.misses);
          end
          run_v_d     = 1'b1;
          run_slot_d  = cur_q;
          run_start_d = req_q.now_us;
          rkind_d     = KIND_DISPATCH;
          rid_d       = cur_q;
          rstart_d    = req_q.now_us;
          state_d     = S_RESP;
        end
        wdata = e;
        we    = 1'b1;
        ent_d = e;
      end

      S_AD_CALC: begin
        e = ent_q;
        n = sat_add(ent_q.next_rel, ent_q.period);
        if (ent_q.period != '0 && n <= ad_base_q && n != {TIME_W{1'b1}}) begin
          // Behind by at least a period: catch up with the remainder.
          div_start = 1'b1;
          div_dvd   = ad_base_q - n;
          state_d   = S_AD_WAIT;
        end else begin
          if (ent_q.period != '0) begin
            e.next_rel = n;
          end
          wdata   = e;
          we      = 1'b1;
          ent_d   = e;
          state_d = ad_walk_q ? S_WK_SEL : S_RESP;
        end
      end

      S_AD_WAIT: begin
        if (div_done) begin
          e          = ent_q;
          nr         = sat_add(ad_base_q - div_rem, ent_q.period);
          e.next_rel = nr;
          wdata      = e;
          we         = 1'b1;
          ent_d      = e;
          state_d    = ad_walk_q ? S_WK_SEL : S_RESP;
        end
      end

      S_END: begin
        if (flag_q) begin
          vs_n = (vstreak_q == 8'hFF) ? vstreak_q : vstreak_q + 8'd1;
          cs_n = '0;
        end else begin
          vs_n = '0;
          cs_n = (cstreak_q == 8'hFF) ? cstreak_q : cstreak_q + 8'd1;
        end
        if (vs_n >= emg_q) begin
          mnext = MODE_EMERGENCY;
        end else if (vs_n >= deg_q) begin
          mnext = MODE_DEGRADED;
        end else if (cs_n >= rec_q) begin
          mnext = MODE_NORMAL;
        end
        if (mnext != mode_q) begin
          trans_d = inc16(trans_q);
        end
        mode_d    = mnext;
        vstreak_d = vs_n;
        cstreak_d = cs_n;
        pass_d    = 1'b0;
        cclass_d  = '0;
        cslot_d   = '0;
        rkind_d   = KIND_DONE;
        state_d   = S_RESP;
      end

      S_RESP: begin
        out_d              = '0;
        out_d.kind         = rkind_q;
        out_d.task_id      = rid_q;
        out_d.start_time   = rstart_q;
        out_d.sched_mode   = mode_q;
        out_d.tasks_in_use = used_q;
        out_d.mode_changes = trans_q;
        if (rfill_q) begin
          out_d.miss_count     = ent_q.misses;
          out_d.skip_count     = ent_q.skips;
          out_d.denial_count   = ent_q.denials;
          out_d.overrun_total  = ent_q.overruns;
          out_d.last_run_us    = ent_q.last_exec;
          out_d.longest_run_us = ent_q.max_exec;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      mode_q      <= MODE_NORMAL;
      flag_q      <= 1'b0;
      vstreak_q   <= '0;
      cstreak_q   <= '0;
      cclass_q    <= '0;
      cslot_q     <= '0;
      pass_q      <= 1'b0;
      run_v_q     <= 1'b0;
      run_slot_q  <= '0;
      run_start_q <= '0;
      trans_q     <= '0;
      done_q      <= 1'b0;
      deg_q       <= 8'd2;
      emg_q       <= 8'd5;
      rec_q       <= 8'd10;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      mode_q      <= mode_d;
      flag_q      <= flag_d;
      vstreak_q   <= vstreak_d;
      cstreak_q   <= cstreak_d;
      cclass_q    <= cclass_d;
      cslot_q     <= cslot_d;
      pass_q      <= pass_d;
      run_v_q     <= run_v_d;
      run_slot_q  <= run_slot_d;
      run_start_q <= run_start_d;
      trans_q     <= trans_d;
      done_q      <= done_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DEGRADED:  deg_q <= cfg_data_i;
          CFG_EMERGENCY: emg_q <= cfg_data_i;
          CFG_RECOVERY:  rec_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ent_q      <= ent_d;
    cur_q      <= cur_d;
    hr_idx_q   <= hr_idx_d;
    hr_found_q <= hr_found_d;
    hr_rel_q   <= hr_rel_d;
    rkind_q    <= rkind_d;
    rid_q      <= rid_d;
    rstart_q   <= rstart_d;
    rfill_q    <= rfill_d;
    ad_base_q  <= ad_base_d;
    ad_walk_q  <= ad_walk_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  // A result only follows a cycle in which the sequencer was working.
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without a request in flight");

  // No result directly follows another: never two in a row.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back results");

  // A task can only be running while a scheduling pass is open.
  a_run_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_v_q |-> pass_q) else $error("running task outside a pass");

  // The table never holds more tasks than it has slots.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(NTASK)) else $error("task count beyond table size");
`endif

endmodule

### rtl/btrd_ram.sv
// ----------------------------------------------------------------------------
// btrd_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module btrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/btrd_rem.sv
// ----------------------------------------------------------------------------
// btrd_rem: iterative remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module btrd_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [btrd_pkg::TIME_W-1:0] dividend_i,
  input  logic [btrd_pkg::TIME_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [btrd_pkg::TIME_W-1:0] rem_o
);
  import btrd_pkg::*;

  localparam int unsigned CW = $clog2(TIME_W);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [TIME_W:0]   rem_q, rem_d, shifted;
  logic [TIME_W-1:0] dvd_q, dvd_d, dvs_q, dvs_d;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    shifted = {rem_q[TIME_W-1:0], dvd_q[TIME_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = (shifted >= {1'b0, dvs_q}) ? shifted - {1'b0, dvs_q} : shifted;
      dvd_d = {dvd_q[TIME_W-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(TIME_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[TIME_W-1:0];

endmodule
